FILE: src/tfs_pkg.sv
// Shared types, constants and helper functions of the transfer function simulator.
package tfs_pkg;

  localparam int unsigned NumTaps  = 4;
  localparam int unsigned MaxOrder = 4;
  localparam int unsigned RkStages = 4;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned OpW      = 33;
  localparam int unsigned AccW     = 66;
  localparam int unsigned WgtW     = 19;
  localparam int unsigned DivInW   = 36;
  localparam int unsigned DivOutW  = 34;

  // Register indexes
  localparam logic [2:0] RegNumLen    = 3'd0;
  localparam logic [2:0] RegDenOrder  = 3'd1;
  localparam logic [2:0] RegNumCoeffs = 3'd2;
  localparam logic [2:0] RegDenCoeffs = 3'd3;
  localparam logic [2:0] RegMode      = 3'd4;
  localparam logic [2:0] RegTimeStep  = 3'd5;
  localparam logic [2:0] RegInvStep   = 3'd6;

  // RK weights, Q16
  localparam logic signed [WgtW-1:0] WgtZero = 19'sd0;
  localparam logic signed [WgtW-1:0] WgtHalf = 19'sd32768;
  localparam logic signed [WgtW-1:0] WgtOne  = 19'sd65536;
  localparam logic signed [WgtW-1:0] WgtTwo  = 19'sd131072;
  localparam logic signed [WgtW-1:0] WgtG1   = 19'sd13573;
  localparam logic signed [WgtW-1:0] WgtG2   = 19'sd19195;
  localparam logic signed [WgtW-1:0] WgtG3   = -19'sd46341;
  localparam logic signed [WgtW-1:0] WgtG4   = 19'sd111877;
  localparam logic signed [WgtW-1:0] WgtG5   = 19'sd38390;
  localparam logic signed [WgtW-1:0] WgtG6   = 19'sd223754;

  localparam logic signed [AccW-1:0] SatHi =
    {{(AccW-DataW+1){1'b0}}, {(DataW-1){1'b1}}};
  localparam logic signed [AccW-1:0] SatLo =
    {{(AccW-DataW+1){1'b1}}, {(DataW-1){1'b0}}};
  localparam logic signed [AccW-1:0] RndQ12  = AccW'(2048);
  localparam logic signed [AccW-1:0] RndQ16  = AccW'(32768);
  localparam logic signed [AccW-1:0] RndFinal = AccW'(196608);

  typedef logic signed [DataW-1:0] data_t;

  typedef struct packed {
    data_t sample_in;
  } in_beat_t;

  typedef struct packed {
    data_t response;
    logic  saturated;
  } out_beat_t;

  typedef struct packed {
    logic [2:0]  len;
    logic [2:0]  order;
    logic [63:0] num;
    logic [63:0] den;
    logic        gill;
    logic [31:0] dt;
    logic [31:0] inv;
    logic        clr;
  } cfg_t;

  typedef struct packed {
    logic  clip;
    data_t val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [AccW-1:0] v);
    sat_t r;
    if (v > SatHi) begin
      r.clip = 1'b1;
      r.val  = {1'b0, {(DataW-1){1'b1}}};
    end else if (v < SatLo) begin
      r.clip = 1'b1;
      r.val  = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r.clip = 1'b0;
      r.val  = v[DataW-1:0];
    end
    return r;
  endfunction

  // Weight of one term of a stage point
  function automatic logic signed [WgtW-1:0] pt_wgt(input logic [1:0] stage,
                                                    input logic term, input logic gill);
    logic signed [WgtW-1:0] w;
    case (stage)
      2'd0:    w = term ? WgtZero : WgtHalf;
      2'd1:    w = term ? (gill ? WgtG2 : WgtHalf) : (gill ? WgtG1 : WgtZero);
      2'd2:    w = term ? (gill ? WgtG4 : WgtOne) : (gill ? WgtG3 : WgtZero);
      default: w = WgtZero;
    endcase
    return w;
  endfunction

  // Slope set used by one term of a stage point
  function automatic logic [1:0] pt_ksel(input logic [1:0] stage, input logic term);
    logic [1:0] s;
    if (stage == 2'd0) s = 2'd0;
    else if (!term)    s = stage - 2'd1;
    else               s = stage;
    return s;
  endfunction

  // Weight of one slope in the final update
  function automatic logic signed [WgtW-1:0] fn_wgt(input logic [1:0] term,
                                                    input logic gill);
    logic signed [WgtW-1:0] w;
    case (term)
      2'd1:    w = gill ? WgtG5 : WgtTwo;
      2'd2:    w = gill ? WgtG6 : WgtTwo;
      default: w = WgtOne;
    endcase
    return w;
  endfunction

endpackage

FILE: src/tfs_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
interface tfs_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/tfs_cfg.sv
// Configuration register file with structure-change clear.
module tfs_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           we_i,
  input  logic [2:0]     idx_i,
  input  logic [63:0]    data_i,
  output tfs_pkg::cfg_t  cfg_o
);
  import tfs_pkg::*;

  logic [2:0]  num_len_q, den_order_q;
  logic [63:0] num_q, den_q;
  logic        mode_q;
  logic [31:0] dt_q, inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_len_q   <= 3'd1;
      den_order_q <= 3'd0;
      num_q       <= 64'd4096;
      den_q       <= 64'd0;
      mode_q      <= 1'b0;
      dt_q        <= 32'd65536;
      inv_q       <= 32'd65536;
    end else if (we_i) begin
      unique case (idx_i)
        RegNumLen:    num_len_q   <= data_i[2:0];
        RegDenOrder:  den_order_q <= data_i[2:0];
        RegNumCoeffs: num_q       <= data_i;
        RegDenCoeffs: den_q       <= data_i;
        RegMode:      mode_q      <= data_i[0];
        RegTimeStep:  dt_q        <= data_i[31:0];
        RegInvStep:   inv_q       <= data_i[31:0];
        default: ;
      endcase
    end
  end

  // Effective tap count and order
  always_comb begin
    cfg_o.len = num_len_q;
    if (num_len_q == 3'd0) cfg_o.len = 3'd1;
    else if (num_len_q > 3'(NumTaps)) cfg_o.len = 3'(NumTaps);
    cfg_o.order = (den_order_q > 3'(MaxOrder)) ? 3'(MaxOrder) : den_order_q;
    cfg_o.num  = num_q;
    cfg_o.den  = den_q;
    cfg_o.gill = mode_q;
    cfg_o.dt   = dt_q;
    cfg_o.inv  = inv_q;
    cfg_o.clr  = we_i && (idx_i <= RegDenCoeffs);
  end

endmodule

FILE: src/tfs_mul.sv
// Shared signed multiplier with registered product.
module tfs_mul (
  input  logic                                  clk_i,
  input  logic signed [tfs_pkg::OpW-1:0]        a_i,
  input  logic signed [tfs_pkg::OpW-1:0]        b_i,
  output logic signed [tfs_pkg::AccW-1:0]       p_o
);
  import tfs_pkg::*;

  logic signed [AccW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= AccW'(a_i) * AccW'(b_i);
  end

  assign p_o = p_q;

endmodule

FILE: src/tfs_div6.sv
// Floor division by six, seven quotient bits per cycle.
module tfs_div6 (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [tfs_pkg::DivInW-1:0]    v_i,
  output logic                                 done_o,
  output logic signed [tfs_pkg::DivOutW-1:0]   q_o
);
  import tfs_pkg::*;

  localparam int unsigned DigW  = 7;
  localparam int unsigned Digs  = 6;
  localparam int unsigned WW    = DigW * Digs;
  // Offset is a multiple of six that makes the dividend positive
  localparam logic [37:0] DivOff = 38'h30_0000_0000;
  localparam logic [36:0] QOff   = 37'h8_0000_0000;

  logic [WW-1:0] w_q, quot_q;
  logic [2:0]    rem_q;
  logic [2:0]    cnt_q;
  logic          busy_q, done_q;

  logic [37:0]   w_init;
  logic [9:0]    val;
  logic [19:0]   recip;
  logic [6:0]    qd;
  logic [9:0]    rnew;
  logic [36:0]   qfix;

  assign w_init = 38'(signed'(v_i)) + DivOff;
  assign val    = {rem_q, w_q[WW-1 -: DigW]};
  assign recip  = 20'(val) * 20'd683;
  assign qd     = recip[18:12];
  assign rnew   = val - 10'(qd) * 10'd6;
  assign qfix   = {1'b0, quot_q[35:0]} - QOff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
      rem_q  <= 3'd0;
      w_q    <= '0;
      quot_q <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == 3'(Digs - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd0;
        rem_q  <= 3'd0;
        w_q    <= {4'b0, w_init};
      end else if (busy_q) begin
        w_q    <= {w_q[WW-DigW-1:0], {DigW{1'b0}}};
        quot_q <= {quot_q[WW-DigW-1:0], qd};
        rem_q  <= rnew[2:0];
        cnt_q  <= cnt_q + 3'd1;
        if (cnt_q == 3'(Digs - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = qfix[DivOutW-1:0];

endmodule

FILE: src/transfer_function_simulator.sv
// Top level: sequencer and datapath of the transfer function simulator.
// One item at a time: the shared multiplier and divide-by-six unit set the rate.
// A new beat is taken while a finished result still waits in the output register.
// Reset (async, active low) restores register defaults and clears history and states.
module transfer_function_simulator (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [63:0]          cfg_data_i,
  tfs_stream_if.sink           in_i,
  tfs_stream_if.source         out_o
);
  import tfs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DIFF, S_SCL_M, S_SCL_A, S_CF_M, S_CF_A, S_U,
    S_ROW, S_DER_M, S_DER_A, S_DER_F, S_K_M, S_K_A,
    S_PT_M, S_PT_A, S_PT_W, S_FN_M, S_FN_A, S_FN_D, S_DIV, S_OUT
  } state_e;

  cfg_t cfg;

  tfs_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  state_e state_q;
  data_t  hist_q  [NumTaps];
  data_t  x_q     [MaxOrder];
  data_t  xt_q    [MaxOrder];
  data_t  slope_q [RkStages][MaxOrder];
  logic signed [AccW-1:0] acc_q;
  data_t  d_q, f_q, u_q;
  logic [1:0] tap_q, t_q, stage_q, row_q, term_q;
  logic   clip_q;
  logic   out_valid_q, out_sat_q;
  data_t  out_resp_q;

  // Shared multiplier
  logic signed [OpW-1:0]  mul_a, mul_b;
  logic signed [AccW-1:0] prod;

  tfs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Divide-by-six unit for the final update
  logic                      div_start, div_done;
  logic signed [DivInW-1:0]  div_v;
  logic signed [DivOutW-1:0] div_q;
  logic signed [AccW-1:0]    fin_sum;

  assign fin_sum   = (acc_q + RndFinal) >>> 16;
  assign div_v     = fin_sum[DivInW-1:0];
  assign div_start = (state_q == S_FN_D);

  tfs_div6 u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .v_i     (div_v),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // Tap bookkeeping
  logic [2:0] k_cur;
  assign k_cur = 3'(cfg.len - 3'd1 - {1'b0, tap_q});

  // Binomial difference over the newest samples
  logic signed [35:0] e0, e1, e2, e3, diff_sum;
  assign e0 = 36'(hist_q[0]);
  assign e1 = 36'(hist_q[1]);
  assign e2 = 36'(hist_q[2]);
  assign e3 = 36'(hist_q[3]);

  always_comb begin
    case (k_cur[1:0])
      2'd0:    diff_sum = e0;
      2'd1:    diff_sum = e0 - e1;
      2'd2:    diff_sum = e0 - (e1 <<< 1) + e2;
      default: diff_sum = e0 - ((e1 <<< 1) + e1) + ((e2 <<< 1) + e2) - e3;
    endcase
  end

  // State read port: one address per cycle
  logic [1:0] ra;
  data_t      x_rd, xt_rd, p_rd;
  logic [2:0] der_idx;

  assign der_idx = 3'(cfg.order - 3'd1 - {1'b0, term_q});

  always_comb begin
    case (state_q)
      S_ROW:   ra = row_q + 2'd1;
      S_DER_M: ra = der_idx[1:0];
      S_OUT:   ra = 2'd0;
      default: ra = row_q;
    endcase
  end

  assign x_rd  = x_q[ra];
  assign xt_rd = xt_q[ra];
  assign p_rd  = (stage_q == 2'd0) ? x_rd : xt_rd;

  // Slope read port
  logic [1:0] ksel;
  data_t      slope_rd;
  assign ksel     = (state_q == S_PT_M) ? pt_ksel(stage_q, term_q[0]) : term_q;
  assign slope_rd = slope_q[ksel][row_q];

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SCL_M: begin
        mul_a = OpW'(d_q);
        mul_b = signed'({1'b0, cfg.inv});
      end
      S_CF_M: begin
        mul_a = OpW'(signed'(cfg.num[CoefW*tap_q +: CoefW]));
        mul_b = OpW'(d_q);
      end
      S_DER_M: begin
        mul_a = OpW'(signed'(cfg.den[CoefW*term_q +: CoefW]));
        mul_b = OpW'(p_rd);
      end
      S_K_M: begin
        mul_a = OpW'(f_q);
        mul_b = signed'({1'b0, cfg.dt});
      end
      S_PT_M: begin
        mul_a = OpW'(slope_rd);
        mul_b = OpW'(pt_wgt(stage_q, term_q[0], cfg.gill));
      end
      S_FN_M: begin
        mul_a = OpW'(slope_rd);
        mul_b = OpW'(fn_wgt(term_q, cfg.gill));
      end
      default: ;
    endcase
  end

  // Rounding and saturation
  sat_t sat_diff, sat_p16, sat_u, sat_f, sat_pt, sat_fn;
  assign sat_diff = sat32(AccW'(diff_sum));
  assign sat_p16  = sat32((prod + RndQ16) >>> 16);
  assign sat_u    = sat32(acc_q);
  assign sat_f    = sat32((acc_q + RndQ12) >>> 12);
  assign sat_pt   = sat32(AccW'(x_rd) + ((acc_q + RndQ16) >>> 16));
  assign sat_fn   = sat32(AccW'(x_rd) + AccW'(div_q));

  logic slot_free;
  assign slot_free = !out_valid_q || out_o.ready;

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = '{response: out_resp_q, saturated: out_sat_q};

  // Sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hist_q      <= '{default: '0};
      x_q         <= '{default: '0};
      xt_q        <= '{default: '0};
      slope_q     <= '{default: '{default: '0}};
      acc_q       <= '0;
      d_q         <= '0;
      f_q         <= '0;
      u_q         <= '0;
      tap_q       <= 2'd0;
      t_q         <= 2'd0;
      stage_q     <= 2'd0;
      row_q       <= 2'd0;
      term_q      <= 2'd0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_sat_q   <= 1'b0;
      out_resp_q  <= '0;
    end else begin
      // output register: load a finished item, drop on handshake
      if (state_q == S_OUT && slot_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;

      unique case (state_q)
        // structure change clears history and states; only written while idle
        S_IDLE: begin
          if (in_i.valid) begin
            for (int j = NumTaps - 1; j > 0; j--)
              hist_q[j] <= cfg.clr ? '0 : hist_q[j-1];
            hist_q[0] <= in_i.data.sample_in;
            acc_q     <= '0;
            tap_q     <= 2'd0;
            clip_q    <= 1'b0;
            state_q   <= S_DIFF;
          end else if (cfg.clr) begin
            hist_q <= '{default: '0};
          end
          if (cfg.clr) x_q <= '{default: '0};
        end
        // numerator: difference, k scalings, coefficient term
        S_DIFF: begin
          d_q <= sat_diff.val;
          if (sat_diff.clip) clip_q <= 1'b1;
          t_q <= 2'd0;
          state_q <= (k_cur == 3'd0) ? S_CF_M : S_SCL_M;
        end
        S_SCL_M: state_q <= S_SCL_A;
        S_SCL_A: begin
          d_q <= sat_p16.val;
          if (sat_p16.clip) clip_q <= 1'b1;
          t_q <= t_q + 2'd1;
          state_q <= ({1'b0, t_q} + 3'd1 == k_cur) ? S_CF_M : S_SCL_M;
        end
        S_CF_M: state_q <= S_CF_A;
        S_CF_A: begin
          acc_q <= acc_q + ((prod + RndQ12) >>> 12);
          if ({1'b0, tap_q} + 3'd1 == cfg.len) begin
            state_q <= S_U;
          end else begin
            tap_q   <= tap_q + 2'd1;
            state_q <= S_DIFF;
          end
        end
        S_U: begin
          u_q <= sat_u.val;
          if (sat_u.clip) clip_q <= 1'b1;
          stage_q <= 2'd0;
          row_q   <= 2'd0;
          state_q <= (cfg.order == 3'd0) ? S_OUT : S_ROW;
        end
        // slope rows: shift rows pass through, last row sums the denominator
        S_ROW: begin
          if ({1'b0, row_q} + 3'd1 < cfg.order) begin
            f_q     <= p_rd;
            state_q <= S_K_M;
          end else begin
            acc_q   <= AccW'(u_q) <<< 12;
            term_q  <= 2'd0;
            state_q <= S_DER_M;
          end
        end
        S_DER_M: state_q <= S_DER_A;
        S_DER_A: begin
          acc_q <= acc_q - prod;
          if ({1'b0, term_q} + 3'd1 == cfg.order) begin
            state_q <= S_DER_F;
          end else begin
            term_q  <= term_q + 2'd1;
            state_q <= S_DER_M;
          end
        end
        S_DER_F: begin
          f_q <= sat_f.val;
          if (sat_f.clip) clip_q <= 1'b1;
          state_q <= S_K_M;
        end
        S_K_M: state_q <= S_K_A;
        S_K_A: begin
          slope_q[stage_q][row_q] <= sat_p16.val;
          if (sat_p16.clip) clip_q <= 1'b1;
          if ({1'b0, row_q} + 3'd1 == cfg.order) begin
            row_q   <= 2'd0;
            term_q  <= 2'd0;
            state_q <= (stage_q == 2'(RkStages - 1)) ? S_FN_M : S_PT_M;
          end else begin
            row_q   <= row_q + 2'd1;
            state_q <= S_ROW;
          end
        end
        // stage point: two weighted slopes per row
        S_PT_M: state_q <= S_PT_A;
        S_PT_A: begin
          if (term_q == 2'd0) begin
            acc_q   <= prod;
            term_q  <= 2'd1;
            state_q <= S_PT_M;
          end else begin
            acc_q   <= acc_q + prod;
            state_q <= S_PT_W;
          end
        end
        S_PT_W: begin
          xt_q[row_q] <= sat_pt.val;
          if (sat_pt.clip) clip_q <= 1'b1;
          term_q <= 2'd0;
          if ({1'b0, row_q} + 3'd1 == cfg.order) begin
            stage_q <= stage_q + 2'd1;
            row_q   <= 2'd0;
            state_q <= S_ROW;
          end else begin
            row_q   <= row_q + 2'd1;
            state_q <= S_PT_M;
          end
        end
        // final update: four weighted slopes, then divide by six
        S_FN_M: state_q <= S_FN_A;
        S_FN_A: begin
          acc_q <= (term_q == 2'd0) ? prod : acc_q + prod;
          if (term_q == 2'd3) begin
            state_q <= S_FN_D;
          end else begin
            term_q  <= term_q + 2'd1;
            state_q <= S_FN_M;
          end
        end
        S_FN_D: state_q <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            x_q[row_q] <= sat_fn.val;
            if (sat_fn.clip) clip_q <= 1'b1;
            term_q <= 2'd0;
            if ({1'b0, row_q} + 3'd1 == cfg.order) begin
              state_q <= S_OUT;
            end else begin
              row_q   <= row_q + 2'd1;
              state_q <= S_FN_M;
            end
          end
        end
        S_OUT: begin
          if (slot_free) begin
            out_resp_q  <= (cfg.order == 3'd0) ? u_q : x_rd;
            out_sat_q   <= clip_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Assertions
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken again while busy");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside its wait state");

  a_result_posted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && slot_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished result not posted");

endmodule
